// ===== hw/rtl/tksd_pkg.sv =====
// Shared types, codes and the escape sequence table of the terminal key sequence decoder.
package tksd_pkg;

  localparam int unsigned VALUE_W   = 21;
  localparam int unsigned SEQ_COUNT = 20;
  localparam int unsigned HEAD_LEN  = 4;
  localparam logic [7:0]  ESC_BYTE  = 8'h1B;
  localparam logic [7:0]  CR_BYTE   = 8'h0D;
  localparam logic [7:0]  LF_BYTE   = 8'h0A;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_CHAR    = 2'd1,
    KIND_SPECIAL = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    NL_NONE = 2'd0,
    NL_LF   = 2'd1,
    NL_CR   = 2'd2
  } newline_e;

  // how much the scan consumes from the head of the store
  typedef struct packed {
    logic       clear;  // discard everything
    logic [2:0] count;  // else drop this many bytes
  } drop_t;

  typedef struct packed {
    logic [2:0] len;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [3:0] id;
  } seq_t;

  localparam seq_t SEQ_TABLE [SEQ_COUNT] = '{
    '{3'd4, 8'h1B, 8'h5B, 8'h5B, 8'h41, 4'd0},   // ESC [ [ A  F1
    '{3'd4, 8'h1B, 8'h5B, 8'h5B, 8'h42, 4'd1},   // ESC [ [ B  F2
    '{3'd4, 8'h1B, 8'h5B, 8'h5B, 8'h43, 4'd2},   // ESC [ [ C  F3
    '{3'd4, 8'h1B, 8'h5B, 8'h5B, 8'h44, 4'd3},   // ESC [ [ D  F4
    '{3'd4, 8'h1B, 8'h5B, 8'h31, 8'h7E, 4'd4},   // ESC [ 1 ~  home
    '{3'd4, 8'h1B, 8'h5B, 8'h32, 8'h7E, 4'd5},   // ESC [ 2 ~  insert
    '{3'd4, 8'h1B, 8'h5B, 8'h33, 8'h7E, 4'd6},   // ESC [ 3 ~  del
    '{3'd4, 8'h1B, 8'h5B, 8'h34, 8'h7E, 4'd7},   // ESC [ 4 ~  end
    '{3'd4, 8'h1B, 8'h5B, 8'h35, 8'h7E, 4'd8},   // ESC [ 5 ~  pgup
    '{3'd4, 8'h1B, 8'h5B, 8'h36, 8'h7E, 4'd9},   // ESC [ 6 ~  pgdown
    '{3'd3, 8'h1B, 8'h5B, 8'h41, 8'h00, 4'd10},  // ESC [ A    up
    '{3'd3, 8'h1B, 8'h5B, 8'h42, 8'h00, 4'd11},  // ESC [ B    down
    '{3'd3, 8'h1B, 8'h5B, 8'h44, 8'h00, 4'd12},  // ESC [ D    left
    '{3'd3, 8'h1B, 8'h5B, 8'h43, 8'h00, 4'd13},  // ESC [ C    right
    '{3'd3, 8'h1B, 8'h5B, 8'h48, 8'h00, 4'd4},   // ESC [ H    home
    '{3'd3, 8'h1B, 8'h5B, 8'h46, 8'h00, 4'd7},   // ESC [ F    end
    '{3'd3, 8'h1B, 8'h4F, 8'h50, 8'h00, 4'd0},   // ESC O P    F1
    '{3'd3, 8'h1B, 8'h4F, 8'h51, 8'h00, 4'd1},   // ESC O Q    F2
    '{3'd3, 8'h1B, 8'h4F, 8'h52, 8'h00, 4'd2},   // ESC O R    F3
    '{3'd3, 8'h1B, 8'h4F, 8'h53, 8'h00, 4'd3}    // ESC O S    F4
  };

endpackage

// ===== hw/rtl/tksd_store.sv =====
// Byte store: append, head view and front drop of the pending terminal bytes.
module tksd_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned CNT_W = 5
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   byte_valid_i,
  input  logic [7:0]             byte_i,
  input  tksd_pkg::drop_t        drop_i,
  output logic [3:0][7:0]        head_o,
  output logic [CNT_W-1:0]       fill_o,
  output logic [CNT_W-1:0]       pending_o,
  output logic                   dropped_o
);

  logic [7:0]       store_q [DEPTH];
  logic [7:0]       store_d [DEPTH];
  logic [7:0]       app     [DEPTH];
  logic [CNT_W-1:0] fill_q;
  logic [CNT_W-1:0] fill_d;
  logic             full;
  logic             push;

  assign full      = (fill_q == CNT_W'(DEPTH));
  assign push      = byte_valid_i && !full;
  assign dropped_o = byte_valid_i && full;
  assign fill_o    = fill_q + CNT_W'(push);

  // store as seen after the append
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      app[k] = (push && fill_q == CNT_W'(k)) ? byte_i : store_q[k];
    end
  end

  always_comb begin
    for (int k = 0; k < tksd_pkg::HEAD_LEN; k++) begin
      head_o[k] = app[k];
    end
  end

  assign fill_d    = drop_i.clear ? '0 : fill_o - CNT_W'(drop_i.count);
  assign pending_o = fill_d;

  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      store_d[k] = app[k];
      case (drop_i.count)
        3'd1:    if (k + 1 < DEPTH) store_d[k] = app[(k + 1) % DEPTH];
        3'd2:    if (k + 2 < DEPTH) store_d[k] = app[(k + 2) % DEPTH];
        3'd3:    if (k + 3 < DEPTH) store_d[k] = app[(k + 3) % DEPTH];
        3'd4:    if (k + 4 < DEPTH) store_d[k] = app[(k + 4) % DEPTH];
        default: store_d[k] = app[k];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (step_i) begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      store_q <= store_d;
    end
  end

endmodule

// ===== hw/rtl/tksd_scan.sv =====
// Single scan of the store head: escape sequence match, then UTF-8 decode, then flush rules.
module tksd_scan #(
  parameter int unsigned CNT_W = 5
) (
  input  logic [3:0][7:0]                head_i,
  input  logic [CNT_W-1:0]               fill_i,
  input  logic                           flush_i,
  output tksd_pkg::kind_e                kind_o,
  output logic [tksd_pkg::VALUE_W-1:0]   value_o,
  output tksd_pkg::drop_t                drop_o
);

  logic                           seq_hit;
  logic [3:0]                     seq_id;
  logic [2:0]                     seq_len;
  logic [2:0]                     lead_len;
  logic [tksd_pkg::VALUE_W-1:0]   cp;
  logic                           is_esc;

  assign is_esc = (head_i[0] == tksd_pkg::ESC_BYTE);

  // reverse sweep so the lowest table entry wins
  always_comb begin
    seq_hit = 1'b0;
    seq_id  = '0;
    seq_len = '0;
    for (int i = tksd_pkg::SEQ_COUNT - 1; i >= 0; i--) begin
      if (fill_i >= CNT_W'(tksd_pkg::SEQ_TABLE[i].len) &&
          head_i[0] == tksd_pkg::SEQ_TABLE[i].b0 &&
          head_i[1] == tksd_pkg::SEQ_TABLE[i].b1 &&
          head_i[2] == tksd_pkg::SEQ_TABLE[i].b2 &&
          (tksd_pkg::SEQ_TABLE[i].len == 3'd3 ||
           head_i[3] == tksd_pkg::SEQ_TABLE[i].b3)) begin
        seq_hit = 1'b1;
        seq_id  = tksd_pkg::SEQ_TABLE[i].id;
        seq_len = tksd_pkg::SEQ_TABLE[i].len;
      end
    end
  end

  always_comb begin
    if (!head_i[0][7])                lead_len = 3'd1;
    else if (head_i[0][7:5] == 3'b110) lead_len = 3'd2;
    else if (head_i[0][7:4] == 4'b1110) lead_len = 3'd3;
    else if (head_i[0][7:3] == 5'b11110) lead_len = 3'd4;
    else                               lead_len = 3'd0;
  end

  // continuation bytes are taken unchecked
  always_comb begin
    case (lead_len)
      3'd1:    cp = {14'd0, head_i[0][6:0]};
      3'd2:    cp = {10'd0, head_i[0][4:0], head_i[1][5:0]};
      3'd3:    cp = {5'd0, head_i[0][3:0], head_i[1][5:0], head_i[2][5:0]};
      3'd4:    cp = {head_i[0][2:0], head_i[1][5:0], head_i[2][5:0], head_i[3][5:0]};
      default: cp = '0;
    endcase
  end

  always_comb begin
    kind_o  = tksd_pkg::KIND_NONE;
    value_o = '0;
    drop_o  = '{clear: 1'b0, count: 3'd0};
    if (fill_i == '0) begin
      kind_o = tksd_pkg::KIND_NONE;
    end else if (seq_hit) begin
      kind_o  = tksd_pkg::KIND_SPECIAL;
      value_o = tksd_pkg::VALUE_W'(seq_id);
      drop_o  = '{clear: 1'b0, count: seq_len};
    end else if (flush_i && is_esc && fill_i > CNT_W'(1)) begin
      drop_o = '{clear: 1'b1, count: 3'd0};
    end else if (!is_esc && lead_len != 3'd0 && fill_i >= CNT_W'(lead_len)) begin
      kind_o  = tksd_pkg::KIND_CHAR;
      value_o = cp;
      drop_o  = '{clear: 1'b0, count: lead_len};
    end else if (flush_i) begin
      if (fill_i == CNT_W'(1)) begin
        kind_o  = tksd_pkg::KIND_CHAR;
        value_o = tksd_pkg::VALUE_W'(head_i[0]);
      end
      drop_o = '{clear: 1'b1, count: 3'd0};
    end
  end

endmodule

// ===== hw/rtl/terminal_key_sequence_decoder.sv =====
// Top level: terminal byte stream to key codes, with input and result registers.
//
//   channel | dir | tdata                          | tuser
//   s_axis  | in  | data_byte[7:0]                 | cmd (1 = flush)
//   m_axis  | out | key_value, pending_bytes,      | key_kind[1:0]
//           |     | overflow_drop, zero pad        |
//
// One item per cycle sustained while m_axis takes results. An item sits in
// the input register, where the store scan, the store update and Enter
// folding run, and then lands in the result register.
// Reset clears the fill count, the newline memory and both valid flags; the
// byte contents are not cleared and are only read below the fill count.
// When m_axis stalls, the result holds, one more item waits in the input
// register and s_axis_tready_o then drops until the result is taken.
module terminal_key_sequence_decoder #(
  parameter int unsigned BUFFER_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,   // [7:0] data_byte
  input  logic                s_axis_tuser_i,   // [0] cmd
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [20:0] key_value, then pending_bytes, then overflow_drop, zero pad to bytes
  output logic [((tksd_pkg::VALUE_W + $clog2(BUFFER_DEPTH + 1) + 1 + 7) / 8) * 8 - 1:0]
                              m_axis_tdata_o,
  output logic [1:0]          m_axis_tuser_o    // [1:0] key_kind
);

  localparam int unsigned CNT_W  = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned DATA_W = ((tksd_pkg::VALUE_W + CNT_W + 1 + 7) / 8) * 8;
  localparam int unsigned PAD_W  = DATA_W - tksd_pkg::VALUE_W - CNT_W - 1;

  // input register
  logic       in_valid_q;
  logic       in_cmd_q;
  logic [7:0] in_byte_q;

  // result register
  logic                         out_valid_q;
  tksd_pkg::kind_e              out_kind_q, out_kind_d;
  logic [tksd_pkg::VALUE_W-1:0] out_value_q, out_value_d;
  logic [CNT_W-1:0]             out_pending_q;
  logic                         out_drop_q;

  tksd_pkg::newline_e last_nl_q, last_nl_d;

  logic                         advance;
  logic                         flush;
  logic [3:0][7:0]              head;
  logic [CNT_W-1:0]             fill;
  logic [CNT_W-1:0]             pending;
  logic                         dropped;
  tksd_pkg::drop_t              drop;
  tksd_pkg::kind_e              scan_kind;
  logic [tksd_pkg::VALUE_W-1:0] scan_value;
  tksd_pkg::newline_e           nl;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign flush           = in_cmd_q || (in_byte_q == 8'h00);  // zero byte flushes too

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_cmd_q  <= s_axis_tuser_i;
      in_byte_q <= s_axis_tdata_i;
    end
  end

  tksd_store #(
    .DEPTH (BUFFER_DEPTH),
    .CNT_W (CNT_W)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .byte_valid_i (!flush),
    .byte_i       (in_byte_q),
    .drop_i       (drop),
    .head_o       (head),
    .fill_o       (fill),
    .pending_o    (pending),
    .dropped_o    (dropped)
  );

  tksd_scan #(
    .CNT_W (CNT_W)
  ) u_scan (
    .head_i  (head),
    .fill_i  (fill),
    .flush_i (flush),
    .kind_o  (scan_kind),
    .value_o (scan_value),
    .drop_o  (drop)
  );

  // Enter folding: CR becomes LF, the opposite half of a CR/LF pair vanishes
  always_comb begin
    out_kind_d  = scan_kind;
    out_value_d = scan_value;
    last_nl_d   = last_nl_q;
    nl          = tksd_pkg::NL_NONE;
    if (scan_kind == tksd_pkg::KIND_CHAR &&
        scan_value == tksd_pkg::VALUE_W'(tksd_pkg::LF_BYTE)) begin
      nl = tksd_pkg::NL_LF;
    end else if (scan_kind == tksd_pkg::KIND_CHAR &&
                 scan_value == tksd_pkg::VALUE_W'(tksd_pkg::CR_BYTE)) begin
      nl = tksd_pkg::NL_CR;
    end
    if (nl != tksd_pkg::NL_NONE) begin
      if (last_nl_q == tksd_pkg::NL_NONE) begin
        last_nl_d = nl;
      end else if (nl != last_nl_q) begin
        last_nl_d   = tksd_pkg::NL_NONE;
        out_kind_d  = tksd_pkg::KIND_NONE;
        out_value_d = '0;
      end
      if (out_kind_d == tksd_pkg::KIND_CHAR) begin
        out_value_d = tksd_pkg::VALUE_W'(tksd_pkg::LF_BYTE);
      end
    end else if (scan_kind != tksd_pkg::KIND_NONE) begin
      last_nl_d = tksd_pkg::NL_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      last_nl_q   <= tksd_pkg::NL_NONE;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        last_nl_q   <= last_nl_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_kind_q    <= out_kind_d;
      out_value_q   <= out_value_d;
      out_pending_q <= pending;
      out_drop_q    <= dropped;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tdata_o  = {{PAD_W{1'b0}}, out_drop_q, out_pending_q, out_value_q};

  // no-key results carry a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_kind_q == tksd_pkg::KIND_NONE |-> out_value_q == '0)
    else $error("no-key result with nonzero value");

  // special ids are 0..13
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_kind_q == tksd_pkg::KIND_SPECIAL
      |-> out_value_q < tksd_pkg::VALUE_W'(14))
    else $error("special key id out of range");

  // CR never leaves the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_kind_q == tksd_pkg::KIND_CHAR
      |-> out_value_q != tksd_pkg::VALUE_W'(tksd_pkg::CR_BYTE))
    else $error("CR not folded");

  // store occupancy stays within depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> pending <= CNT_W'(BUFFER_DEPTH) && fill <= CNT_W'(BUFFER_DEPTH))
    else $error("byte store fill beyond depth");

  // a dropped byte means nothing was appended
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && dropped |-> fill == CNT_W'(BUFFER_DEPTH))
    else $error("overflow flagged with room left");

endmodule

// ===== verif/terminal_key_sequence_decoder_tb.sv =====
// Stream testbench for the terminal key sequence decoder, checked against a key decode predictor.
`timescale 1ns / 100ps

module terminal_key_sequence_decoder_tb;

  localparam int unsigned STORE_DEPTH = 16;
  localparam int unsigned PEND_W      = $clog2(STORE_DEPTH + 1);
  localparam int unsigned RES_W       = ((tksd_pkg::VALUE_W + PEND_W + 1 + 7) / 8) * 8;
  localparam int unsigned NUM_ITEMS   = 1150;
  localparam int unsigned TAIL_ITEMS  = 60;    // no idling once this few items remain
  localparam int unsigned HOLD_AT     = 400;   // items sent before the long sink stall
  localparam int unsigned HOLD_LEN    = 80;    // cycles of the long sink stall
  localparam int unsigned STALL_LIMIT = 1000;  // cycles with no handshake at all
  localparam int unsigned DRAIN       = 10;    // extra cycles waited after the run empties
  localparam logic        CMD_BYTE    = 1'b0;
  localparam logic        CMD_FLUSH   = 1'b1;

  // Escape sequence table, first byte in the low bits of seq.
  typedef struct packed {
    logic [2:0]  len;
    logic [31:0] seq;
    logic [3:0]  id;
  } esc_key_t;

  localparam esc_key_t ESC_KEYS [tksd_pkg::SEQ_COUNT] = '{
    '{3'd4, 32'h415B5B1B, 4'd0},   // F1
    '{3'd4, 32'h425B5B1B, 4'd1},   // F2
    '{3'd4, 32'h435B5B1B, 4'd2},   // F3
    '{3'd4, 32'h445B5B1B, 4'd3},   // F4
    '{3'd4, 32'h7E315B1B, 4'd4},   // home
    '{3'd4, 32'h7E325B1B, 4'd5},   // insert
    '{3'd4, 32'h7E335B1B, 4'd6},   // del
    '{3'd4, 32'h7E345B1B, 4'd7},   // end
    '{3'd4, 32'h7E355B1B, 4'd8},   // pgup
    '{3'd4, 32'h7E365B1B, 4'd9},   // pgdown
    '{3'd3, 32'h00415B1B, 4'd10},  // up
    '{3'd3, 32'h00425B1B, 4'd11},  // down
    '{3'd3, 32'h00445B1B, 4'd12},  // left
    '{3'd3, 32'h00435B1B, 4'd13},  // right
    '{3'd3, 32'h00485B1B, 4'd4},   // home, short form
    '{3'd3, 32'h00465B1B, 4'd7},   // end, short form
    '{3'd3, 32'h00504F1B, 4'd0},   // F1, SS3 form
    '{3'd3, 32'h00514F1B, 4'd1},   // F2, SS3 form
    '{3'd3, 32'h00524F1B, 4'd2},   // F3, SS3 form
    '{3'd3, 32'h00534F1B, 4'd3}    // F4, SS3 form
  };

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
  } term_item_t;

  typedef struct packed {
    tksd_pkg::kind_e              kind;
    logic [tksd_pkg::VALUE_W-1:0] value;
    logic [PEND_W-1:0]            pending;
    logic                         drop;
  } key_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // DUT signals; the inputs are driven to known values from time zero
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = 8'h00;   // [7:0] data_byte
  logic             s_tuser = 1'b0;    // [0] cmd
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [RES_W-1:0] m_tdata;           // [20:0] key_value, [25:21] pending_bytes, [26] drop
  logic [1:0]       m_tuser;           // [1:0] key_kind

  term_item_t  term_q [$];    // items still to be offered
  key_result_t key_q [$];     // predicted keys, oldest first
  term_item_t  next_item;

  // predictor state
  logic [7:0]         kb_store [STORE_DEPTH];
  int unsigned        kb_fill;
  tksd_pkg::newline_e kb_nl;

  int unsigned n_sent       = 0;
  int unsigned err_cnt      = 0;
  int unsigned stall_cycles = 0;
  int unsigned src_gap      = 0;
  int unsigned sink_gap     = 0;
  int unsigned hold_cnt     = 0;
  logic        hold_done    = 1'b0;

  terminal_key_sequence_decoder #(
    .BUFFER_DEPTH(STORE_DEPTH)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Consume n bytes from the head of the store (all of it if n covers it).
  function automatic void store_drop(int unsigned n);
    if (n >= kb_fill) begin
      kb_fill = 0;
    end else begin
      for (int i = 0; i < kb_fill - n; i++) kb_store[i] = kb_store[i + n];
      kb_fill = kb_fill - n;
    end
  endfunction

  // One item in, one key out. Mirrors the block's store scan and Enter folding.
  function automatic key_result_t decode_key(logic cmd, logic [7:0] b);
    key_result_t        r;
    logic               flush;
    logic               done;
    logic               hit;
    logic [7:0]         lead;
    logic [31:0]        cp;
    int unsigned        n;
    tksd_pkg::newline_e nl;

    r     = '0;
    flush = (cmd == CMD_FLUSH) || (b == 8'h00);
    done  = 1'b0;

    if (!flush) begin
      if (kb_fill < STORE_DEPTH) begin
        kb_store[kb_fill] = b;
        kb_fill++;
      end else begin
        r.drop = 1'b1;
      end
    end

    if (kb_fill != 0) begin
      // escape sequences, first match in table order wins
      for (int s = 0; s < tksd_pkg::SEQ_COUNT && !done; s++) begin
        hit = (ESC_KEYS[s].len <= kb_fill);
        for (int j = 0; j < 4; j++) begin
          if (hit && j < ESC_KEYS[s].len && kb_store[j] != ESC_KEYS[s].seq[8*j +: 8]) hit = 1'b0;
        end
        if (hit) begin
          r.kind  = tksd_pkg::KIND_SPECIAL;
          r.value = tksd_pkg::VALUE_W'(ESC_KEYS[s].id);
          store_drop(ESC_KEYS[s].len);
          done = 1'b1;
        end
      end

      // unknown escape sequence on flush: throw it all away
      if (!done && flush && kb_store[0] == tksd_pkg::ESC_BYTE && kb_fill > 1) begin
        store_drop(kb_fill);
        done = 1'b1;
      end

      // UTF-8; continuation bytes are taken as they are
      if (!done && kb_store[0] != tksd_pkg::ESC_BYTE) begin
        lead = kb_store[0];
        if (lead < 8'h80) n = 1;
        else if (lead >= 8'hC0 && lead <= 8'hDF) n = 2;
        else if (lead >= 8'hE0 && lead <= 8'hEF) n = 3;
        else if (lead >= 8'hF0 && lead <= 8'hF7) n = 4;
        else n = 0;
        if (n != 0 && n <= kb_fill) begin
          case (n)
            1:       cp = {24'h0, lead};
            2:       cp = {24'h0, lead & 8'h1F};
            3:       cp = {24'h0, lead & 8'h0F};
            default: cp = {24'h0, lead & 8'h07};
          endcase
          for (int i = 1; i < n; i++) cp = (cp << 6) | {26'h0, kb_store[i][5:0]};
          r.kind  = tksd_pkg::KIND_CHAR;
          r.value = cp[tksd_pkg::VALUE_W-1:0];
          store_drop(n);
          done = 1'b1;
        end
      end

      // flush leftovers: a lone byte comes out as itself
      if (!done && flush) begin
        if (kb_fill == 1) begin
          r.kind  = tksd_pkg::KIND_CHAR;
          r.value = tksd_pkg::VALUE_W'(kb_store[0]);
        end
        store_drop(kb_fill);
      end
    end

    // Enter folding
    nl = tksd_pkg::NL_NONE;
    if (r.kind == tksd_pkg::KIND_CHAR && r.value == tksd_pkg::VALUE_W'(tksd_pkg::LF_BYTE))
      nl = tksd_pkg::NL_LF;
    if (r.kind == tksd_pkg::KIND_CHAR && r.value == tksd_pkg::VALUE_W'(tksd_pkg::CR_BYTE))
      nl = tksd_pkg::NL_CR;
    if (nl != tksd_pkg::NL_NONE) begin
      if (kb_nl == tksd_pkg::NL_NONE) begin
        kb_nl = nl;
      end else if (nl != kb_nl) begin
        kb_nl   = tksd_pkg::NL_NONE;   // opposite kind of the pair: swallowed
        r.kind  = tksd_pkg::KIND_NONE;
        r.value = '0;
      end
      if (r.kind == tksd_pkg::KIND_CHAR) r.value = tksd_pkg::VALUE_W'(tksd_pkg::LF_BYTE);
    end else if (r.kind != tksd_pkg::KIND_NONE) begin
      kb_nl = tksd_pkg::NL_NONE;
    end

    r.pending = PEND_W'(kb_fill);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic add_item(logic cmd, logic [7:0] b);
    term_q.push_back('{cmd: cmd, data: b});
  endtask

  task automatic add_flush();
    add_item(CMD_FLUSH, 8'($urandom_range(0, 255)));
  endtask

  task automatic add_esc_key(int unsigned k, int unsigned nbytes);
    for (int j = 0; j < nbytes; j++) add_item(CMD_BYTE, ESC_KEYS[k].seq[8*j +: 8]);
  endtask

  task automatic add_directed();
    add_esc_key(10, 3);                   // ESC [ A, up
    add_esc_key(19, 3);                   // ESC O S, F4
    add_item(CMD_BYTE, 8'hF7);            // largest 4-byte code point
    add_item(CMD_BYTE, 8'hBF);
    add_item(CMD_BYTE, 8'hBF);
    add_item(CMD_BYTE, 8'hBF);
    add_item(CMD_BYTE, tksd_pkg::CR_BYTE);  // CR becomes LF and is remembered
    add_item(CMD_BYTE, tksd_pkg::LF_BYTE);  // LF after CR is swallowed
    add_item(CMD_BYTE, tksd_pkg::CR_BYTE);
    add_item(CMD_BYTE, tksd_pkg::CR_BYTE);  // same kind again still gives LF
    add_item(CMD_BYTE, 8'hFF);            // invalid lead waits for a flush
    add_item(CMD_BYTE, 8'h41);
    add_item(CMD_FLUSH, 8'hFF);           // flush with several leftovers: no key
    add_item(CMD_BYTE, tksd_pkg::ESC_BYTE);
    add_item(CMD_FLUSH, 8'h00);           // lone ESC comes out as a character
    add_item(CMD_BYTE, tksd_pkg::ESC_BYTE);
    add_item(CMD_BYTE, 8'h5B);
    add_item(CMD_BYTE, 8'h00);            // zero byte flushes an escape prefix
    add_item(CMD_BYTE, 8'h7F);
    add_item(CMD_BYTE, 8'h80);            // stray continuation byte
    add_flush();                          // one byte left: emitted as itself
  endtask

  // Random part: mostly well-formed keys with random content, plus noise,
  // broken escapes, flushes and the odd flood that overruns the store.
  task automatic add_stream();
    int unsigned pick;
    int unsigned k;
    int unsigned n;
    int unsigned end_pick;

    while (term_q.size() < NUM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        // complete escape sequence
        k = $urandom_range(0, tksd_pkg::SEQ_COUNT - 1);
        add_esc_key(k, ESC_KEYS[k].len);
      end else if (pick < 45) begin
        // UTF-8 character of random length
        n = $urandom_range(1, 4);
        case (n)
          1:       add_item(CMD_BYTE, 8'($urandom_range(8'h01, 8'h7F)));
          2:       add_item(CMD_BYTE, 8'($urandom_range(8'hC0, 8'hDF)));
          3:       add_item(CMD_BYTE, 8'($urandom_range(8'hE0, 8'hEF)));
          default: add_item(CMD_BYTE, 8'($urandom_range(8'hF0, 8'hF7)));
        endcase
        for (int i = 1; i < n; i++) begin
          if ($urandom_range(0, 9) == 0) add_item(CMD_BYTE, 8'($urandom_range(1, 255)));
          else add_item(CMD_BYTE, 8'($urandom_range(8'h80, 8'hBF)));
        end
      end else if (pick < 55) begin
        add_item(CMD_BYTE, $urandom_range(0, 1) ? tksd_pkg::CR_BYTE : tksd_pkg::LF_BYTE);
      end else if (pick < 65) begin
        // broken escape: a proper prefix, then a flush, a zero or a stray byte
        k = $urandom_range(0, tksd_pkg::SEQ_COUNT - 1);
        add_esc_key(k, $urandom_range(1, ESC_KEYS[k].len - 1));
        end_pick = $urandom_range(0, 2);
        if (end_pick == 0) add_flush();
        else if (end_pick == 1) add_item(CMD_BYTE, 8'h00);
        else add_item(CMD_BYTE, 8'($urandom_range(1, 255)));
      end else if (pick < 73) begin
        add_flush();
      end else if (pick < 77) begin
        add_item(CMD_BYTE, 8'h00);
      end else if (pick < 79) begin
        // invalid lead blocks the head, the store fills and usually drops bytes
        if ($urandom_range(0, 1)) add_item(CMD_BYTE, 8'($urandom_range(8'h80, 8'hBF)));
        else add_item(CMD_BYTE, 8'($urandom_range(8'hF8, 8'hFF)));
        n = $urandom_range(STORE_DEPTH - 1, STORE_DEPTH + 4);
        for (int i = 0; i < n; i++) add_item(CMD_BYTE, 8'($urandom_range(1, 255)));
        add_flush();
      end else begin
        add_item(CMD_BYTE, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued items, idles in short random bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'h00;
      s_tuser  <= 1'b0;
      src_gap  <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        key_q.push_back(decode_key(s_tuser, s_tdata));
        n_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap != 0) begin
          src_gap  <= src_gap - 1;
          s_tvalid <= 1'b0;
        end else if (term_q.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0) begin
          src_gap  <= $urandom_range(0, 2);
          s_tvalid <= 1'b0;
        end else if (term_q.size() != 0) begin
          next_item = term_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= next_item.data;
          s_tuser  <= next_item.cmd;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sink ready: random short stalls, one long hold-off to back the block up
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready  <= 1'b0;
      sink_gap  <= 0;
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else begin
      if (!hold_done && n_sent >= HOLD_AT) begin
        if (hold_cnt < HOLD_LEN) begin
          hold_cnt <= hold_cnt + 1;
          m_tready <= 1'b0;
        end else begin
          hold_done <= 1'b1;
          m_tready  <= 1'b1;
        end
      end else if (sink_gap != 0) begin
        sink_gap <= sink_gap - 1;
        m_tready <= 1'b0;
      end else if (term_q.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
        sink_gap <= $urandom_range(0, 2);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each key against the oldest prediction; stall watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    key_result_t want;
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;

      if (m_tvalid && m_tready) begin
        if (key_q.size() == 0) begin
          if (err_cnt < 10) $display("ERROR: key with no prediction waiting, tuser %0d tdata %h",
                                     m_tuser, m_tdata);
          err_cnt++;
        end else begin
          want = key_q.pop_front();
          if (m_tuser !== want.kind ||
              m_tdata[tksd_pkg::VALUE_W-1:0] !== want.value ||
              m_tdata[tksd_pkg::VALUE_W +: PEND_W] !== want.pending ||
              m_tdata[tksd_pkg::VALUE_W + PEND_W] !== want.drop) begin
            if (err_cnt < 10) begin
              $display("ERROR: key mismatch: expected kind %0d value %h pending %0d drop %0b",
                       want.kind, want.value, want.pending, want.drop);
              $display("       got kind %0d value %h pending %0d drop %0b",
                       m_tuser, m_tdata[tksd_pkg::VALUE_W-1:0],
                       m_tdata[tksd_pkg::VALUE_W +: PEND_W],
                       m_tdata[tksd_pkg::VALUE_W + PEND_W]);
            end
            err_cnt++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < STORE_DEPTH; i++) kb_store[i] = 8'h00;
    kb_fill = 0;
    kb_nl   = tksd_pkg::NL_NONE;
    add_directed();
    add_stream();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(term_q.size() == 0 && !s_tvalid && key_q.size() == 0) &&
           stall_cycles < STALL_LIMIT)
      @(posedge clk_i);
    if (stall_cycles < STALL_LIMIT) repeat (DRAIN) @(posedge clk_i);

    if (stall_cycles < STALL_LIMIT && err_cnt == 0 && key_q.size() == 0) begin
      $display("PASS terminal_key_sequence_decoder");
    end else begin
      $display("FAIL terminal_key_sequence_decoder");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tksd_pkg.sv
hw/rtl/tksd_store.sv
hw/rtl/tksd_scan.sv
hw/rtl/terminal_key_sequence_decoder.sv
verif/terminal_key_sequence_decoder_tb.sv
